>>> hw/rtl/tcqsc_pkg.sv
// Package: shared constants and types for the two-class job queue.
`default_nettype none
package tcqsc_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam logic [7:0] LIMIT_RESET = 8'd5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        t_status     status;
        logic [15:0] served_id;
        logic        served_premium;
    } t_rsp;

    // Pending word between the decision register and the result register.
    typedef struct packed {
        t_status status;
        logic    served;
        logic    sel_premium;
    } t_stage;
endpackage
`default_nettype wire

>>> hw/rtl/tcqsc_req_if.sv
// Interface: request channel (push or pop word).
`default_nettype none
interface tcqsc_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] job_id;
    logic        is_premium;

    modport source (output valid, output op, output job_id, output is_premium, input ready);
    modport sink   (input valid, input op, input job_id, input is_premium, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tcqsc_rsp_if.sv
// Interface: result channel.
`default_nettype none
interface tcqsc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] served_id;
    logic        served_premium;

    modport source (output valid, output status, output served_id, output served_premium,
                    input ready);
    modport sink   (input valid, input status, input served_id, input served_premium,
                    output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tcqsc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module tcqsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = tcqsc_pkg::QUEUE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> hw/rtl/two_class_queue_starvation_cap.sv
// Top level: two-class FIFO job queue with strict priority and a premium run limit.
// Results go through the decision register, then the result register, before o_rsp.
// Throughput: one request per cycle unless o_rsp.ready low stalls the result register.
// Reset (i_rst_n low, synchronous): queues empty, run count 0, limit 5.
// Queue RAM contents are not cleared.
`default_nettype none
module two_class_queue_starvation_cap #(
    parameter int QUEUE_DEPTH = tcqsc_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    tcqsc_req_if.sink       i_req,
    tcqsc_rsp_if.source     o_rsp
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    logic [7:0]    r_limit;
    logic [7:0]    r_run, n_run;
    logic [AW-1:0] r_phead, n_phead, r_fhead, n_fhead;
    logic [CW-1:0] r_pcnt, n_pcnt, r_fcnt, n_fcnt;

    logic                r_s1_valid;
    tcqsc_pkg::t_stage   r_s1, n_s1;
    logic                r_out_valid;
    tcqsc_pkg::t_rsp     r_out, n_out;

    logic          acc, is_pop, prem_nz, free_nz, p_full, f_full;
    logic          run_below, take_prem, s1_move;
    logic          p_we, p_re, f_we, f_re;
    logic [SW-1:0] p_sum, f_sum;
    logic [AW-1:0] p_tail, f_tail, p_addr, f_addr, p_hinc, f_hinc;
    logic [15:0]   p_rdata, f_rdata;

    assign s1_move     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_move;
    assign acc         = i_req.valid && i_req.ready;
    assign is_pop      = (i_req.op == tcqsc_pkg::OP_POP);

    assign prem_nz   = (r_pcnt != '0);
    assign free_nz   = (r_fcnt != '0);
    assign p_full    = (r_pcnt == CW'(QUEUE_DEPTH));
    assign f_full    = (r_fcnt == CW'(QUEUE_DEPTH));
    assign run_below = (r_run < r_limit);
    assign take_prem = prem_nz && (run_below || !free_nz);

    // Tail = head + count, wrapped.
    always_comb begin
        p_sum  = SW'(r_phead) + SW'(r_pcnt);
        f_sum  = SW'(r_fhead) + SW'(r_fcnt);
        p_tail = (p_sum >= SW'(QUEUE_DEPTH)) ? AW'(p_sum - SW'(QUEUE_DEPTH)) : AW'(p_sum);
        f_tail = (f_sum >= SW'(QUEUE_DEPTH)) ? AW'(f_sum - SW'(QUEUE_DEPTH)) : AW'(f_sum);
        p_hinc = (r_phead == AW'(QUEUE_DEPTH - 1)) ? '0 : r_phead + AW'(1);
        f_hinc = (r_fhead == AW'(QUEUE_DEPTH - 1)) ? '0 : r_fhead + AW'(1);
    end

    assign p_we   = acc && !is_pop && i_req.is_premium && !p_full;
    assign f_we   = acc && !is_pop && !i_req.is_premium && !f_full;
    assign p_re   = acc && is_pop && take_prem;
    assign f_re   = acc && is_pop && !take_prem && free_nz;
    assign p_addr = is_pop ? r_phead : p_tail;
    assign f_addr = is_pop ? r_fhead : f_tail;

    tcqsc_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_prem_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_re    (p_re),
        .i_addr  (p_addr),
        .i_wdata (i_req.job_id),
        .o_rdata (p_rdata)
    );

    tcqsc_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_re    (f_re),
        .i_addr  (f_addr),
        .i_wdata (i_req.job_id),
        .o_rdata (f_rdata)
    );

    always_comb begin
        n_phead = r_phead;
        n_fhead = r_fhead;
        n_pcnt  = r_pcnt;
        n_fcnt  = r_fcnt;
        n_run   = r_run;
        n_s1    = r_s1;
        if (acc) begin
            n_s1.served      = p_re || f_re;
            n_s1.sel_premium = p_re;
            if (!is_pop) begin
                n_s1.status = (i_req.is_premium ? p_full : f_full) ?
                              tcqsc_pkg::ST_FULL : tcqsc_pkg::ST_OK;
            end else begin
                n_s1.status = (prem_nz || free_nz) ? tcqsc_pkg::ST_OK : tcqsc_pkg::ST_EMPTY;
            end
            if (p_we) n_pcnt = r_pcnt + CW'(1);
            if (f_we) n_fcnt = r_fcnt + CW'(1);
            if (p_re) begin
                n_phead = p_hinc;
                n_pcnt  = r_pcnt - CW'(1);
                if (run_below) n_run = r_run + 8'd1;
            end
            if (f_re) begin
                n_fhead = f_hinc;
                n_fcnt  = r_fcnt - CW'(1);
                n_run   = '0;
            end
        end
    end

    always_comb begin
        n_out                = r_out;
        if (s1_move) begin
            n_out.status         = r_s1.status;
            n_out.served_premium = r_s1.served && r_s1.sel_premium;
            n_out.served_id      = !r_s1.served ? '0 : (r_s1.sel_premium ? p_rdata : f_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= tcqsc_pkg::LIMIT_RESET;
            r_run       <= '0;
            r_phead     <= '0;
            r_fhead     <= '0;
            r_pcnt      <= '0;
            r_fcnt      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            r_run   <= n_run;
            r_phead <= n_phead;
            r_fhead <= n_fhead;
            r_pcnt  <= n_pcnt;
            r_fcnt  <= n_fcnt;
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_out <= n_out;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.served_id      = r_out.served_id;
    assign o_rsp.served_premium = r_out.served_premium;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt <= CW'(QUEUE_DEPTH)) && (r_fcnt <= CW'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    a_free_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_re |=> (r_run == '0))
        else $error("free serve did not clear run count");

    a_empty_pop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_pop && !prem_nz && !free_nz) |=>
            ($stable(r_pcnt) && $stable(r_fcnt) && $stable(r_run)))
        else $error("empty pop changed queue state");

    a_unserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != tcqsc_pkg::ST_OK))
            |-> ((r_out.served_id == '0) && !r_out.served_premium))
        else $error("result word inconsistent");

    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(p_re && f_re) && !((p_re || f_re) && (p_we || f_we)))
        else $error("more than one queue access in a cycle");
endmodule
`default_nettype wire

>>> test/two_class_queue_starvation_cap_tb.sv
// Testbench: two-class job queue, random and directed push/pop words checked against a predictor.
`timescale 1ns / 100ps
module two_class_queue_starvation_cap_tb;
    localparam int STALL_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 4;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;

    tcqsc_req_if req_if();
    tcqsc_rsp_if rsp_if();

    two_class_queue_starvation_cap DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [15:0] premium_jobs[$];
    logic [15:0] free_jobs[$];
    logic [7:0]  premium_run = 8'd0;
    logic [7:0]  run_limit = tcqsc_pkg::LIMIT_RESET;
    tcqsc_pkg::t_rsp expected_rsp[$];

    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int full_seen = 0;
    int empty_seen = 0;
    int premium_served = 0;
    int free_served = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    logic stall_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic tcqsc_pkg::t_rsp serve_word(input logic op, input logic [15:0] id,
                                                   input logic prem);
        tcqsc_pkg::t_rsp r;
        r = '0;
        r.status = tcqsc_pkg::ST_OK;
        if (op == tcqsc_pkg::OP_PUSH) begin
            if (prem ? premium_jobs.size() >= tcqsc_pkg::QUEUE_DEPTH :
                       free_jobs.size() >= tcqsc_pkg::QUEUE_DEPTH)
                r.status = tcqsc_pkg::ST_FULL;
            else if (prem)
                premium_jobs.push_back(id);
            else
                free_jobs.push_back(id);
        end else if (premium_jobs.size() == 0 && free_jobs.size() == 0) begin
            r.status = tcqsc_pkg::ST_EMPTY;
        end else if (premium_jobs.size() != 0 &&
                     (premium_run < run_limit || free_jobs.size() == 0)) begin
            r.served_id = premium_jobs.pop_front();
            r.served_premium = 1'b1;
            premium_served++;
            if (premium_run < run_limit)
                premium_run = premium_run + 8'd1;
        end else begin
            r.served_id = free_jobs.pop_front();
            free_served++;
            premium_run = 8'd0;
        end
        return r;
    endfunction

    task automatic send_word(input logic op, input logic [15:0] id, input logic prem);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.job_id     <= id;
        req_if.is_premium <= prem;
        do @(posedge i_clk); while (!req_if.ready);
        expected_rsp.push_back(serve_word(op, id, prem));
        words_sent++;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_run_limit(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        run_limit = value;
    endtask

    task automatic push_job(input logic [15:0] id, input logic prem);
        send_word(tcqsc_pkg::OP_PUSH, id, prem);
    endtask

    task automatic pop_job();
        send_word(tcqsc_pkg::OP_POP, 16'($urandom), 1'($urandom));
    endtask

    task automatic test_basic_serve();
        pop_job();
        push_job(16'hFFFF, 1'b1);
        push_job(16'h0000, 1'b0);
        pop_job();
        pop_job();
        pop_job();
        drain();
    endtask

    task automatic test_run_limit_one();
        write_run_limit(8'd1);
        push_job(16'h8001, 1'b1);
        push_job(16'h7FFE, 1'b1);
        push_job(16'hA5A5, 1'b0);
        push_job(16'h5A5A, 1'b0);
        repeat (5) pop_job();
        drain();
    endtask

    task automatic test_zero_limit();
        write_run_limit(8'd0);
        push_job(16'h0001, 1'b1);
        push_job(16'h0002, 1'b0);
        pop_job();
        pop_job();
        drain();
    endtask

    task automatic test_lowered_limit();
        write_run_limit(8'd255);
        push_job(16'h1111, 1'b1);
        push_job(16'h2222, 1'b1);
        push_job(16'h3333, 1'b1);
        push_job(16'h4444, 1'b0);
        repeat (3) pop_job();
        drain();
        write_run_limit(8'd2);
        pop_job();
        drain();
    endtask

    task automatic random_mix(input int n_items, input int push_pct);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < push_pct)
                push_job(16'($urandom), 1'($urandom));
            else
                pop_job();
        end
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct <= snk_pct;
        for (int blk = 0; blk < 4; blk++) begin
            drain();
            case (blk)
                0: write_run_limit(8'd1);
                1: write_run_limit(8'($urandom_range(2, 254)));
                2: write_run_limit(8'd255);
                default: write_run_limit(8'd0);
            endcase
            case (blk)
                0: random_mix(92, 60);
                1: random_mix(92, 50);
                2: random_mix(92, 75);
                default: random_mix(92, 40);
            endcase
        end
        drain();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct <= 0;
        write_run_limit(tcqsc_pkg::LIMIT_RESET);
        stall_req <= 1'b1;
        @(posedge i_clk);
        stall_req <= 1'b0;
        for (int n = 0; n < 24; n++)
            push_job(16'($urandom), 1'b1);
        for (int n = 0; n < 16; n++)
            push_job(16'($urandom), 1'b0);
        drain();
        repeat (36) pop_job();
        drain();
    endtask

    // result checker and receiver side
    always @(posedge i_clk) begin
        tcqsc_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            words_checked++;
            if (expected_rsp.size() == 0) begin
                $error("unexpected result word: status %0d id %h", rsp_if.status,
                       rsp_if.served_id);
                errors++;
            end else begin
                want = expected_rsp.pop_front();
                if (want.status == tcqsc_pkg::ST_FULL) full_seen++;
                if (want.status == tcqsc_pkg::ST_EMPTY) empty_seen++;
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    errors++;
                end
                if (rsp_if.served_id !== want.served_id) begin
                    $error("served_id: expected %h, got %h", want.served_id, rsp_if.served_id);
                    errors++;
                end
                if (rsp_if.served_premium !== want.served_premium) begin
                    $error("served_premium: expected %b, got %b", want.served_premium,
                           rsp_if.served_premium);
                    errors++;
                end
            end
        end
        if (stall_req)
            hold_left <= STALL_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        rsp_if.ready <= !(stall_req || hold_left != 0) &&
                        ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        req_if.valid      = 1'b0;
        req_if.op         = tcqsc_pkg::OP_PUSH;
        req_if.job_id     = 16'd0;
        req_if.is_premium = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_serve();
        test_run_limit_one();
        test_zero_limit();
        test_lowered_limit();
        test_random_phase(9, 73);
        test_random_phase(73, 9);
        test_random_phase(0, 0);
        test_backpressure();
        drain();

        $display("Covered %0d request words, %0d results: %0d premium and %0d free serves,",
                 words_sent, words_checked, premium_served, free_served);
        $display("%0d full pushes, %0d empty pops, run limits 0 to 255 under idle and stall.",
                 full_seen, empty_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/tcqsc_pkg.sv
hw/rtl/tcqsc_req_if.sv
hw/rtl/tcqsc_rsp_if.sv
hw/rtl/tcqsc_ram.sv
hw/rtl/two_class_queue_starvation_cap.sv
test/two_class_queue_starvation_cap_tb.sv
